/* rtl/core/job_table_engine_assert.svh */
// Assertion macros for the job table engine checker.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef JOB_TABLE_ENGINE_ASSERT_SVH
`define JOB_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define JTE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("job table engine check failed");

// Next-cycle implication
`define JTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("job table engine check failed");

`endif

/* rtl/core/jte_pkg.sv */
// Shared types and constants of the job table engine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package jte_pkg;

	// Field widths of one item and one result
	localparam int KIND_W  = 3;
	localparam int PID_W   = 22;
	localparam int JID_W   = 5;
	localparam int STATE_W = 2;
	localparam int SLOT_W  = 4;

	// Stored job ids: the counter can climb past the table size through
	// alternating delete and add, so entries keep the full 32-bit value.
	localparam int JID_STORE_W = 32;

	// Operation codes
	typedef enum logic [KIND_W-1:0] {
		K_ADD  = 3'd0,
		K_DEL  = 3'd1,
		K_FPID = 3'd2,
		K_FJID = 3'd3,
		K_SPID = 3'd4,
		K_SJID = 3'd5,
		K_FG   = 3'd6,
		K_READ = 3'd7
	} kind_t;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NF   = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Run states
	localparam logic [STATE_W-1:0] RUN_UNDEF = 2'd0;
	localparam logic [STATE_W-1:0] RUN_FG    = 2'd1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // latch the item, restart the scan
		logic scan;    // read the entry at the scan index
		logic commit;  // update the table, register the result
	} jte_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;    // scan index is at the final entry
	} jte_stat_t;

endpackage

`default_nettype wire

/* rtl/core/jte_datapath.sv */
// Datapath of the job table engine: table memories, valid bits, scan,
// match capture, job id counter and result registers. Uses jte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jte_datapath #(
	parameter int ENTRIES  = 16,
	parameter int PID_BITS = 22
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  jte_pkg::jte_cmd_t               cmd,
	output jte_pkg::jte_stat_t              stat,
	input  wire [jte_pkg::KIND_W-1:0]       kind,
	input  wire [jte_pkg::PID_W-1:0]        req_pid,
	input  wire [jte_pkg::JID_W-1:0]        req_jid,
	input  wire [jte_pkg::STATE_W-1:0]      req_state,
	input  wire [jte_pkg::SLOT_W-1:0]       req_slot,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [jte_pkg::PID_W-1:0]       out_pid,
	output logic [jte_pkg::JID_W-1:0]       out_jid,
	output logic [jte_pkg::STATE_W-1:0]     out_state,
	output logic [jte_pkg::SLOT_W-1:0]      out_slot
);

	localparam int SW  = $clog2(ENTRIES);
	localparam int PW  = (PID_BITS < jte_pkg::PID_W) ? PID_BITS : jte_pkg::PID_W;
	localparam int JW  = jte_pkg::JID_STORE_W;
	localparam int OPW = jte_pkg::PID_W;
	localparam int OJW = jte_pkg::JID_W;
	localparam int OSW = jte_pkg::SLOT_W;
	localparam int SLW = (SW > OSW) ? SW : OSW;
	localparam logic [SW-1:0] LAST_IDX = SW'(ENTRIES - 1);
	localparam logic [JW-1:0] ENT_J    = JW'(ENTRIES);
	localparam logic [JW-1:0] JID_ONE  = JW'(1);

	// Latched item
	jte_pkg::kind_t                 kind_q;
	logic [PW-1:0]                  pid_q;
	logic [OJW-1:0]                 jid_q;
	logic [jte_pkg::STATE_W-1:0]    st_q;
	logic [OSW-1:0]                 slot_q;

	// Table storage
	logic [PW-1:0]                  pid_mem [ENTRIES];
	logic [JW-1:0]                  jid_mem [ENTRIES];
	logic [jte_pkg::STATE_W-1:0]    st_mem  [ENTRIES];
	logic [ENTRIES-1:0]             valid_q;
	logic [JW-1:0]                  next_q;

	// Scan
	logic [SW-1:0]                  idx_q;
	logic [SW-1:0]                  idx_s1;
	logic                           rd_vld_s1;
	logic                           ent_vld_s1;
	logic [PW-1:0]                  pid_rd_s1;
	logic [JW-1:0]                  jid_rd_s1;
	logic [jte_pkg::STATE_W-1:0]    st_rd_s1;

	// Capture
	logic                           hit_q;
	logic [SW-1:0]                  k_q;
	logic [PW-1:0]                  f_pid_q;
	logic [JW-1:0]                  f_jid_q;
	logic [jte_pkg::STATE_W-1:0]    f_st_q;
	logic [JW-1:0]                  max_q;

	logic [PW-1:0]                  e_pid;
	logic [JW-1:0]                  e_jid;
	logic [jte_pkg::STATE_W-1:0]    e_st;
	logic                           pid_zero;
	logic                           jid_zero;
	logic                           match;
	logic                           take;
	logic [JW-1:0]                  nxt_inc;

	logic [1:0]                     r_status;
	logic [PW-1:0]                  r_pid;
	logic [JW-1:0]                  r_jid;
	logic [jte_pkg::STATE_W-1:0]    r_st;
	logic [SW-1:0]                  r_slot;
	logic                           wr_add;
	logic                           wr_st;

	// Latch the item; pid keeps only its low PID_BITS bits, at most PID_W
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= jte_pkg::kind_t'(kind);
			pid_q  <= req_pid[PW-1:0];
			jid_q  <= req_jid;
			st_q   <= req_state;
			slot_q <= req_slot;
		end
	end

	assign pid_zero  = (pid_q == '0);
	assign jid_zero  = (jid_q == '0);
	assign stat.last = (idx_q == LAST_IDX);

	// Scan index, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			idx_s1     <= '0;
			rd_vld_s1  <= 1'b0;
			ent_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + SW'(1);
			end
			rd_vld_s1  <= cmd.scan;
			idx_s1     <= idx_q;
			ent_vld_s1 <= valid_q[idx_q];
		end
	end

	// Registered memory read
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			pid_rd_s1 <= pid_mem[idx_q];
			jid_rd_s1 <= jid_mem[idx_q];
			st_rd_s1  <= st_mem[idx_q];
		end
	end

	// A free entry reads as all zero
	assign e_pid = ent_vld_s1 ? pid_rd_s1 : '0;
	assign e_jid = ent_vld_s1 ? jid_rd_s1 : '0;
	assign e_st  = ent_vld_s1 ? st_rd_s1 : jte_pkg::RUN_UNDEF;

	// Per-operation match on the entry just read
	always_comb begin
		unique case (kind_q) inside
			jte_pkg::K_ADD:
				match = !pid_zero && (e_pid == '0);
			jte_pkg::K_DEL, jte_pkg::K_FPID, jte_pkg::K_SPID:
				match = !pid_zero && (e_pid == pid_q);
			jte_pkg::K_FJID, jte_pkg::K_SJID:
				match = !jid_zero && (e_jid == JW'(jid_q));
			jte_pkg::K_FG:
				match = (e_st == jte_pkg::RUN_FG);
			jte_pkg::K_READ:
				match = (SLW'(idx_s1) == SLW'(slot_q));
			default:
				match = 1'b0;
		endcase
	end

	assign take = rd_vld_s1 && match && !hit_q;

	// First match wins; largest job id over all other entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			max_q <= '0;
		end else if (rd_vld_s1) begin
			if (take) begin
				k_q     <= idx_s1;
				f_pid_q <= e_pid;
				f_jid_q <= e_jid;
				f_st_q  <= e_st;
			end else if (e_jid > max_q) begin
				max_q <= e_jid;
			end
		end
	end

	// Table writes at commit
	assign wr_add = cmd.commit && hit_q && (kind_q == jte_pkg::K_ADD);
	assign wr_st  = cmd.commit && hit_q && ((kind_q == jte_pkg::K_ADD) ||
		(kind_q == jte_pkg::K_SPID) || (kind_q == jte_pkg::K_SJID));

	always_ff @(posedge clk) begin
		if (wr_add) begin
			pid_mem[k_q] <= pid_q;
			jid_mem[k_q] <= next_q;
		end
		if (wr_st) begin
			st_mem[k_q] <= st_q;
		end
	end

	assign nxt_inc = next_q + JID_ONE;

	// Valid bits and job id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			next_q  <= JID_ONE;
			done    <= 1'b0;
		end else begin
			done <= cmd.commit;
			if (cmd.commit && hit_q) begin
				if (kind_q == jte_pkg::K_ADD) begin
					valid_q[k_q] <= 1'b1;
					next_q <= (nxt_inc > ENT_J) ? JID_ONE : nxt_inc;
				end else if (kind_q == jte_pkg::K_DEL) begin
					valid_q[k_q] <= 1'b0;
					next_q <= max_q + JID_ONE;
				end
			end
		end
	end

	// Result selection
	always_comb begin
		r_status = jte_pkg::ST_NF;
		r_pid    = '0;
		r_jid    = '0;
		r_st     = jte_pkg::RUN_UNDEF;
		r_slot   = '0;
		if (hit_q) begin
			r_status = jte_pkg::ST_OK;
			r_pid    = f_pid_q;
			r_jid    = f_jid_q;
			r_st     = f_st_q;
			r_slot   = k_q;
			case (kind_q) inside
				jte_pkg::K_ADD: begin
					r_pid = pid_q;
					r_jid = next_q;
					r_st  = st_q;
				end
				jte_pkg::K_DEL: begin
					r_st = jte_pkg::RUN_UNDEF;
				end
				jte_pkg::K_SPID, jte_pkg::K_SJID: begin
					r_st = st_q;
				end
				jte_pkg::K_READ: begin
					if (f_pid_q == '0) begin
						r_status = jte_pkg::ST_NF;
					end
				end
				default: begin
				end
			endcase
		end else if ((kind_q == jte_pkg::K_ADD) && !pid_zero) begin
			r_status = jte_pkg::ST_FULL;
		end
	end

	// Result registers, masked to the port widths
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status    <= r_status;
			out_pid   <= OPW'(r_pid);
			out_jid   <= OJW'(r_jid);
			out_state <= r_st;
			out_slot  <= OSW'(r_slot);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/jte_ctrl.sv */
// Controller of the job table engine: sequences latch, scan, drain and
// commit for each item. Uses jte_pkg command and status types.
`timescale 1ns / 1ps
`default_nettype none

module jte_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  jte_pkg::jte_stat_t  stat,
	output jte_pkg::jte_cmd_t   cmd,
	output logic                busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	state_t state_q;

	// Commands decoded from the state
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.commit = (state_q == S_COMMIT);

	// State and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						busy    <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/job_table_engine.sv */
// Top level of the job table engine: controller and datapath.
// Depends on jte_pkg, jte_ctrl and jte_datapath.
//
// An item is taken when start is high and busy is low. The table is scanned
// one entry per cycle through the single read port of the table memory; the
// result is registered after the scan, a drain state and a commit state, and
// appears on the result ports, marked by done for one cycle, and is taken at
// the edge that ends that cycle. Busy drops in that same cycle, so a new item
// can be taken while done is shown, but not before. The result cannot be held
// off. Reset empties the table at once through per-slot valid bits and sets
// the job id counter to 1; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module job_table_engine #(
	parameter int ENTRIES  = 16,
	parameter int PID_BITS = 22
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire [jte_pkg::KIND_W-1:0]       kind,
	input  wire [jte_pkg::PID_W-1:0]        req_pid,
	input  wire [jte_pkg::JID_W-1:0]        req_jid,
	input  wire [jte_pkg::STATE_W-1:0]      req_state,
	input  wire [jte_pkg::SLOT_W-1:0]       req_slot,
	output logic                            busy,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [jte_pkg::PID_W-1:0]       out_pid,
	output logic [jte_pkg::JID_W-1:0]       out_jid,
	output logic [jte_pkg::STATE_W-1:0]     out_state,
	output logic [jte_pkg::SLOT_W-1:0]      out_slot
);

	jte_pkg::jte_cmd_t  cmd;
	jte_pkg::jte_stat_t stat;

	// Sequencer
	jte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Table and result datapath
	jte_datapath #(
		.ENTRIES  (ENTRIES),
		.PID_BITS (PID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (kind),
		.req_pid   (req_pid),
		.req_jid   (req_jid),
		.req_state (req_state),
		.req_slot  (req_slot),
		.done      (done),
		.status    (status),
		.out_pid   (out_pid),
		.out_jid   (out_jid),
		.out_state (out_state),
		.out_slot  (out_slot)
	);

endmodule

`default_nettype wire

/* rtl/core/jte_checker.sv */
// Port-level checker for the job table engine, bound to the top level.
// Depends on jte_pkg and job_table_engine_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "job_table_engine_assert.svh"

module jte_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          start,
	input wire                          busy,
	input wire                          done,
	input wire [1:0]                    status,
	input wire [jte_pkg::PID_W-1:0]     out_pid,
	input wire [jte_pkg::JID_W-1:0]     out_jid,
	input wire [jte_pkg::STATE_W-1:0]   out_state,
	input wire [jte_pkg::SLOT_W-1:0]    out_slot
);

	// A taken item keeps the block busy
	`JTE_ASSERT_NEXT(a_busy_after_take, start && !busy, busy)

	// Busy ends exactly when the result is shown
	`JTE_ASSERT_NOW(a_done_ends_busy, $fell(busy), done)

	// Only defined status codes appear
	`JTE_ASSERT_NOW(a_status_code, done, (status == jte_pkg::ST_OK) || (status == jte_pkg::ST_NF) || (status == jte_pkg::ST_FULL))

	// A full table reports no entry
	`JTE_ASSERT_NOW(a_full_empty, done && (status == jte_pkg::ST_FULL), (out_pid == '0) && (out_jid == '0) && (out_state == '0) && (out_slot == '0))

endmodule

bind job_table_engine jte_checker u_jte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.out_pid   (out_pid),
	.out_jid   (out_jid),
	.out_state (out_state),
	.out_slot  (out_slot)
);

`default_nettype wire

/* verif/tb_job_table_engine.sv */
// Self-checking testbench for job_table_engine: directed and random job operations.
// Depends on jte_pkg and the job_table_engine RTL; holds its own job table predictor.
`timescale 1ns / 1ps

module tb_job_table_engine;
	import jte_pkg::*;

	localparam int ENTRIES = 16;
	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_ITEMS = 1050;
	localparam int DRAIN_CYCLES = ENTRIES + 8;
	localparam logic [PID_W-1:0] PID_MAX = '1;

	// Run states not named in the package
	localparam logic [STATE_W-1:0] RUN_BG   = 2'd2;
	localparam logic [STATE_W-1:0] RUN_STOP = 2'd3;

	typedef struct {
		kind_t                kind;
		logic [PID_W-1:0]     pid;
		logic [JID_W-1:0]     jid;
		logic [STATE_W-1:0]   state;
		logic [SLOT_W-1:0]    slot;
	} job_op_t;

	typedef struct {
		logic [1:0]           status;
		logic [PID_W-1:0]     pid;
		logic [JID_W-1:0]     jid;
		logic [STATE_W-1:0]   state;
		logic [SLOT_W-1:0]    slot;
	} job_reply_t;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #CLK_HALF clk = ~clk;

	// Block inputs, known from time zero
	logic                 start = 1'b0;
	logic [KIND_W-1:0]    kind = '0;
	logic [PID_W-1:0]     req_pid = '0;
	logic [JID_W-1:0]     req_jid = '0;
	logic [STATE_W-1:0]   req_state = '0;
	logic [SLOT_W-1:0]    req_slot = '0;

	wire                  busy;
	wire                  done;
	wire [1:0]            status;
	wire [PID_W-1:0]      out_pid;
	wire [JID_W-1:0]      out_jid;
	wire [STATE_W-1:0]    out_state;
	wire [SLOT_W-1:0]     out_slot;

	job_table_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.req_pid   (req_pid),
		.req_jid   (req_jid),
		.req_state (req_state),
		.req_slot  (req_slot),
		.busy      (busy),
		.done      (done),
		.status    (status),
		.out_pid   (out_pid),
		.out_jid   (out_jid),
		.out_state (out_state),
		.out_slot  (out_slot)
	);

	job_op_t    pending_ops[$];
	job_reply_t expected_replies[$];
	int         fails = 0;

	// Shadow job table; job ids kept at full width since they can climb
	logic [PID_W-1:0]   tbl_pid[ENTRIES] = '{default: '0};
	int unsigned        tbl_jid[ENTRIES] = '{default: 0};
	logic [STATE_W-1:0] tbl_state[ENTRIES] = '{default: '0};
	int unsigned        next_jid = 1;

	// Pids handed out by the stimulus, used to aim lookups at live entries
	logic [PID_W-1:0]   pid_pool[$];

	function automatic int lookup_pid(logic [PID_W-1:0] pid);
		if (pid == '0)
			return -1;
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_pid[i] == pid)
				return i;
		return -1;
	endfunction

	function automatic int lookup_jid(logic [JID_W-1:0] jid);
		if (jid == '0)
			return -1;
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_jid[i] == int'(jid))
				return i;
		return -1;
	endfunction

	// Reply carrying the contents of one slot, or all zero for no slot
	function automatic job_reply_t slot_reply(logic [1:0] st, int idx);
		job_reply_t r;
		r = '{status: st, pid: '0, jid: '0, state: '0, slot: '0};
		if (idx >= 0) begin
			r.pid = tbl_pid[idx];
			r.jid = tbl_jid[idx][JID_W-1:0];
			r.state = tbl_state[idx];
			r.slot = idx[SLOT_W-1:0];
		end
		return r;
	endfunction

	// Apply one job operation to the shadow table and return the expected reply
	function automatic job_reply_t run_job_op(job_op_t op);
		job_reply_t r;
		int hit;
		int unsigned top;
		hit = -1;
		top = 0;
		case (op.kind)
			K_ADD: begin
				if (op.pid == '0) begin
					r = slot_reply(ST_NF, -1);
				end else begin
					for (int i = 0; i < ENTRIES && hit < 0; i++)
						if (tbl_pid[i] == '0)
							hit = i;
					if (hit < 0) begin
						r = slot_reply(ST_FULL, -1);
					end else begin
						tbl_pid[hit] = op.pid;
						tbl_state[hit] = op.state;
						tbl_jid[hit] = next_jid;
						next_jid++;
						if (next_jid > ENTRIES)
							next_jid = 1;
						r = slot_reply(ST_OK, hit);
					end
				end
			end
			K_DEL: begin
				hit = lookup_pid(op.pid);
				if (hit < 0) begin
					r = slot_reply(ST_NF, -1);
				end else begin
					r = slot_reply(ST_OK, hit);
					r.state = RUN_UNDEF;
					tbl_pid[hit] = '0;
					tbl_jid[hit] = 0;
					tbl_state[hit] = RUN_UNDEF;
					for (int i = 0; i < ENTRIES; i++)
						if (tbl_jid[i] > top)
							top = tbl_jid[i];
					next_jid = top + 1;
				end
			end
			K_FPID, K_FJID, K_SPID, K_SJID: begin
				hit = (op.kind == K_FPID || op.kind == K_SPID) ?
					lookup_pid(op.pid) : lookup_jid(op.jid);
				if (hit >= 0 && (op.kind == K_SPID || op.kind == K_SJID))
					tbl_state[hit] = op.state;
				r = slot_reply(hit < 0 ? ST_NF : ST_OK, hit);
			end
			K_FG: begin
				for (int i = 0; i < ENTRIES && hit < 0; i++)
					if (tbl_state[i] == RUN_FG)
						hit = i;
				r = slot_reply(hit < 0 ? ST_NF : ST_OK, hit);
			end
			default: begin
				hit = int'(op.slot);
				if (hit >= ENTRIES)
					r = slot_reply(ST_NF, -1);
				else
					r = slot_reply(tbl_pid[hit] != '0 ? ST_OK : ST_NF, hit);
			end
		endcase
		return r;
	endfunction

	// Stimulus helpers
	task automatic queue_op(kind_t k, logic [PID_W-1:0] pid, logic [JID_W-1:0] jid,
			logic [STATE_W-1:0] st, logic [SLOT_W-1:0] slot);
		pending_ops.push_back('{kind: k, pid: pid, jid: jid, state: st, slot: slot});
	endtask

	function automatic logic [PID_W-1:0] fresh_pid();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return PID_MAX;
			2, 3, 4: return PID_W'($urandom_range(1, 8));
			default: return PID_W'($urandom_range(1, int'(PID_MAX)));
		endcase
	endfunction

	function automatic logic [PID_W-1:0] pool_pid();
		if (pid_pool.size() == 0 || $urandom_range(0, 7) == 0)
			return fresh_pid();
		return pid_pool[$urandom_range(0, pid_pool.size() - 1)];
	endfunction

	function automatic logic [JID_W-1:0] pick_jid();
		if ($urandom_range(0, 5) == 0)
			return JID_W'($urandom);
		return JID_W'($urandom_range(0, ENTRIES + 2));
	endfunction

	// Driver: bursts of items with random gaps counted from each acceptance
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_replies.push_back(run_job_op(pending_ops.pop_front()));
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				start <= 1'b1;
				kind <= pending_ops[0].kind;
				req_pid <= pending_ops[0].pid;
				req_jid <= pending_ops[0].jid;
				req_state <= pending_ops[0].state;
				req_slot <= pending_ops[0].slot;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done strobe is matched against the oldest expectation
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		job_reply_t want;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$error("result with no item outstanding");
				fails++;
			end else begin
				want = expected_replies.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("out_pid", 32'(want.pid), 32'(out_pid));
				check_field("out_jid", 32'(want.jid), 32'(out_jid));
				check_field("out_state", 32'(want.state), 32'(out_state));
				check_field("out_slot", 32'(want.slot), 32'(out_slot));
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int total;
		int idx;
		logic [PID_W-1:0] pid;

		// Directed: zero ids, extremes, duplicates, no foreground, free slots
		queue_op(K_ADD, '0, '0, RUN_FG, '0);
		queue_op(K_ADD, PID_MAX, '0, RUN_FG, '0);
		queue_op(K_ADD, 22'd5, '0, RUN_BG, '0);
		queue_op(K_ADD, 22'd5, '0, RUN_STOP, '0);
		queue_op(K_FPID, 22'd5, '0, '0, '0);
		queue_op(K_FJID, '0, 5'd2, '0, '0);
		queue_op(K_FJID, '0, '0, '0, '0);
		queue_op(K_FPID, '0, '1, '0, '0);
		queue_op(K_SPID, 22'd5, '0, RUN_UNDEF, '0);
		queue_op(K_SJID, '0, 5'd1, RUN_BG, '0);
		queue_op(K_FG, '0, '0, '0, '0);
		queue_op(K_SPID, '0, '0, RUN_FG, '0);
		queue_op(K_SJID, '0, '0, RUN_FG, '0);
		queue_op(K_SJID, '0, '1, RUN_FG, '0);
		queue_op(K_DEL, '0, '0, '0, '0);
		queue_op(K_DEL, 22'd5, '0, '0, '0);
		queue_op(K_DEL, 22'd99, '0, '0, '0);
		queue_op(K_READ, '0, '0, '0, 4'd1);
		queue_op(K_READ, '0, '0, '0, '1);
		queue_op(K_READ, '0, '0, '0, '0);
		queue_op(K_SJID, '0, 5'd3, RUN_FG, '0);
		queue_op(K_FG, '0, '0, '0, '0);
		queue_op(K_ADD, 22'd7, '0, RUN_BG, '0);
		queue_op(K_DEL, PID_MAX, '0, '0, '0);
		pid_pool.push_back(22'd5);
		pid_pool.push_back(22'd7);

		// Random: fill runs, drain runs, mixed traffic and raw noise
		total = pending_ops.size() + RANDOM_ITEMS;
		while (pending_ops.size() < total) begin
			case ($urandom_range(0, 3))
				0: begin
					repeat ($urandom_range(4, 20)) begin
						pid = fresh_pid();
						queue_op(K_ADD, pid, JID_W'($urandom), STATE_W'($urandom),
							SLOT_W'($urandom));
						if (pid != '0)
							pid_pool.push_back(pid);
					end
				end
				1: begin
					repeat ($urandom_range(2, 12)) begin
						if (pid_pool.size() != 0 && $urandom_range(0, 7) != 0) begin
							idx = $urandom_range(0, pid_pool.size() - 1);
							pid = pid_pool[idx];
							pid_pool.delete(idx);
						end else begin
							pid = fresh_pid();
						end
						queue_op(K_DEL, pid, pick_jid(), STATE_W'($urandom), '0);
					end
				end
				2: begin
					repeat ($urandom_range(10, 30)) begin
						pid = pool_pid();
						queue_op(kind_t'($urandom_range(0, 7)), pid, pick_jid(),
							STATE_W'($urandom), SLOT_W'($urandom));
					end
				end
				default: begin
					repeat ($urandom_range(2, 6))
						queue_op(kind_t'($urandom_range(0, 7)), PID_W'($urandom),
							JID_W'($urandom), STATE_W'($urandom), SLOT_W'($urandom));
				end
			endcase
			// keep the pool near the table size
			while (pid_pool.size() > 2 * ENTRIES)
				void'(pid_pool.pop_front());
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("job_table_engine verification clean");
		else
			$display("job_table_engine verification failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("job_table_engine verification failed");
		$finish;
	end

endmodule
